>>> rtl/life_pkg.sv
// Shared types and constants for the toroidal Life engine.
package life_pkg;

  localparam int SIZE_W     = 7;  // width of a grid size register
  localparam int COORD_W    = 6;  // width of a column or row coordinate
  localparam int CFG_ADDR_W = 2;

  // Rule B3/S23 neighbor counts
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_READ    = 2'd1,
    MODE_ADVANCE = 2'd2,
    MODE_NOP     = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               cell_in;
  } item_t;

  typedef struct packed {
    logic cell_out;
    logic status;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_DO,
    ST_EMIT,
    ST_ADV_PRE0,
    ST_ADV_PRE1,
    ST_ADV_PRE2,
    ST_ADV_ROW
  } state_t;

  typedef struct packed {
    logic load;       // capture the item
    logic adv_start;  // preset the row read pointer and the row counter
    logic adv_rd;     // step the wrapping row read pointer
    logic adv_shift;  // shift the three-row window
    logic adv_row;    // write one new row into the spare grid
    logic cell_rd;    // read the captured row
    logic cell_wr;    // write back the modified row
    logic flip;       // swap grids
    logic emit;       // register the result
  } cmd_t;

  typedef struct packed {
    mode_t mode;      // mode of the offered item
    logic  bad;       // offered item addresses a cell outside the grid
    logic  lat_write; // captured item is a cell write
    logic  last_row;  // row counter is on the final row
  } stat_t;

endpackage

>>> rtl/life_automaton_step.sv
// Top level of the toroidal Life engine: size registers, sequencer and datapath.
//
//   channel   direction  handshake            payload
//   item      in         start / busy         item   (mode, col, row, cell_in)
//   result    out        done (one cycle)     result (cell_out, status)
//   config    in         cfg_we               cfg_addr, cfg_data
//
// An item transfers on a rising edge with start high and busy low. A cell read
// or write goes through ST_CELL_RD and ST_CELL_DO; an out-of-grid coordinate or
// an idle mode goes to ST_EMIT. A generation step fills the row window, then
// writes one grid row per cycle through the single read port of the current
// grid RAM. The next item may transfer in the cycle that shows done.
// Reset clears the row valid bits of the current grid, so every cell reads
// dead at once; there is no clearing pass. The receiver cannot stall.
module life_automaton_step #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  life_pkg::item_t                   item,
  output logic                              done,
  output life_pkg::result_t                 result,
  input  logic                              cfg_we,
  input  logic [life_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [life_pkg::SIZE_W-1:0]       cfg_data
);

  import life_pkg::*;

  logic [SIZE_W-1:0] grid_width;
  logic [SIZE_W-1:0] grid_height;
  logic [SIZE_W-1:0] eff_w;
  logic [SIZE_W-1:0] eff_h;
  cmd_t              cmd;
  stat_t             st;

  // Size registers; indexes beyond the list drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= SIZE_W'(50);
      grid_height <= SIZE_W'(50);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp sizes: zero acts as one, anything above the array acts as its edge
  always_comb begin
    if (grid_width == '0) begin
      eff_w = SIZE_W'(1);
    end else if (int'(grid_width) > MAX_COLS) begin
      eff_w = SIZE_W'(MAX_COLS);
    end else begin
      eff_w = grid_width;
    end
    if (grid_height == '0) begin
      eff_h = SIZE_W'(1);
    end else if (int'(grid_height) > MAX_ROWS) begin
      eff_h = SIZE_W'(MAX_ROWS);
    end else begin
      eff_h = grid_height;
    end
  end

  life_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  // Hold two grids and advance one row per cycle on a generation step
  life_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .st     (st),
    .item   (item),
    .eff_w  (eff_w),
    .eff_h  (eff_h),
    .done   (done),
    .result (result)
  );

endmodule

>>> rtl/life_ram.sv
// Generic single-write, single-read RAM with registered read data.
module life_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/life_ctrl.sv
// Sequencer for cell access and generation steps.
module life_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  life_pkg::stat_t st,
  output life_pkg::cmd_t  cmd
);

  import life_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (st.mode)
            MODE_WRITE, MODE_READ: state_next = st.bad ? ST_EMIT : ST_CELL_RD;
            MODE_ADVANCE:          state_next = ST_ADV_PRE0;
            default:               state_next = ST_EMIT;
          endcase
        end
      end
      ST_CELL_RD:  state_next = ST_CELL_DO;
      ST_CELL_DO:  state_next = ST_IDLE;
      ST_EMIT:     state_next = ST_IDLE;
      ST_ADV_PRE0: state_next = ST_ADV_PRE1;
      ST_ADV_PRE1: state_next = ST_ADV_PRE2;
      ST_ADV_PRE2: state_next = ST_ADV_ROW;
      ST_ADV_ROW: begin
        if (st.last_row) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.load      = start;
        cmd.adv_start = start && (st.mode == MODE_ADVANCE);
      end
      ST_CELL_RD: cmd.cell_rd = 1'b1;
      ST_CELL_DO: begin
        cmd.cell_wr = st.lat_write;
        cmd.emit    = 1'b1;
      end
      ST_EMIT:    cmd.emit = 1'b1;
      ST_ADV_PRE0: cmd.adv_rd = 1'b1;
      ST_ADV_PRE1, ST_ADV_PRE2: begin
        cmd.adv_rd    = 1'b1;
        cmd.adv_shift = 1'b1;
      end
      ST_ADV_ROW: begin
        cmd.adv_rd    = 1'b1;
        cmd.adv_shift = 1'b1;
        cmd.adv_row   = 1'b1;
        cmd.flip      = st.last_row;
        cmd.emit      = st.last_row;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> rtl/life_dp.sv
// Grid storage, row window, next-generation row logic and result register.
module life_dp #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  life_pkg::cmd_t                cmd,
  output life_pkg::stat_t               st,
  input  life_pkg::item_t               item,
  input  logic [life_pkg::SIZE_W-1:0]   eff_w,
  input  logic [life_pkg::SIZE_W-1:0]   eff_h,
  output logic                          done,
  output life_pkg::result_t             result
);

  import life_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);

  item_t               lat;
  logic                lat_bad;
  logic                cur_sel;
  logic [MAX_ROWS-1:0] cur_valid;
  logic [RW-1:0]       rd_ptr;
  logic [RW-1:0]       rd_ptr_next;
  logic [RW-1:0]       row_cnt;
  logic [RW-1:0]       rd_addr;
  logic                rd_valid;
  logic [MAX_COLS-1:0] q0;
  logic [MAX_COLS-1:0] q1;
  logic [MAX_COLS-1:0] win_in;
  logic [MAX_COLS-1:0] above;
  logic [MAX_COLS-1:0] mid;
  logic [MAX_COLS-1:0] new_row;
  logic [MAX_COLS-1:0] mod_row;
  logic [MAX_COLS-1:0] wdata;
  logic [RW-1:0]       waddr;
  logic [RW-1:0]       lat_row;
  logic [CW-1:0]       lat_col;
  logic                we0;
  logic                we1;
  logic                in_bad;
  logic                cell_bit;

  // Coordinate check on the offered item
  assign in_bad = ((item.mode == MODE_WRITE) || (item.mode == MODE_READ)) &&
                  (({1'b0, item.col} >= eff_w) || ({1'b0, item.row} >= eff_h));

  assign st.mode      = item.mode;
  assign st.bad       = in_bad;
  assign st.lat_write = (lat.mode == MODE_WRITE);
  assign st.last_row  = (row_cnt == RW'(MAX_ROWS - 1));

  assign lat_row = RW'(lat.row);
  assign lat_col = CW'(lat.col);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lat     <= item;
      lat_bad <= in_bad;
    end
  end

  // Wrapping row read pointer and new-row counter
  always_comb begin
    if (int'(rd_ptr) + 1 >= int'(eff_h)) begin
      rd_ptr_next = '0;
    end else begin
      rd_ptr_next = rd_ptr + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr  <= '0;
      row_cnt <= '0;
    end else if (cmd.adv_start) begin
      rd_ptr  <= RW'(eff_h - SIZE_W'(1));
      row_cnt <= '0;
    end else begin
      if (cmd.adv_rd) begin
        rd_ptr <= rd_ptr_next;
      end
      if (cmd.adv_row) begin
        row_cnt <= row_cnt + RW'(1);
      end
    end
  end

  assign rd_addr = cmd.cell_rd ? lat_row : rd_ptr;

  // Row valid bits of the current grid; rows never written read as dead
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_sel   <= 1'b0;
      cur_valid <= '0;
    end else if (cmd.flip) begin
      cur_sel   <= ~cur_sel;
      cur_valid <= '1;
    end else if (cmd.cell_wr) begin
      cur_valid[lat_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= cur_valid[rd_addr];
  end

  assign win_in = rd_valid ? (cur_sel ? q1 : q0) : '0;

  always_ff @(posedge clk) begin
    if (cmd.adv_shift) begin
      above <= mid;
      mid   <= win_in;
    end
  end

  // One new row: every lane counts its eight wrapped neighbors
  always_comb begin
    logic [CW-1:0] lc;
    logic [CW-1:0] rc;
    logic [3:0]    n;
    new_row = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      lc = (c == 0) ? CW'(eff_w - SIZE_W'(1)) : CW'(c - 1);
      rc = (c + 1 >= int'(eff_w)) ? '0 : CW'(c + 1);
      n  = 4'(above[lc]) + 4'(above[c]) + 4'(above[rc]) +
           4'(mid[lc])   + 4'(mid[rc]) +
           4'(win_in[lc]) + 4'(win_in[c]) + 4'(win_in[rc]);
      new_row[c] = (c < int'(eff_w)) && (int'(row_cnt) < int'(eff_h)) &&
                   ((n == BIRTH_COUNT) || (mid[c] && (n == SURVIVE_COUNT)));
    end
  end

  always_comb begin
    mod_row          = win_in;
    mod_row[lat_col] = lat.cell_in;
  end

  assign cell_bit = win_in[lat_col];

  assign wdata = cmd.cell_wr ? mod_row : new_row;
  assign waddr = cmd.cell_wr ? lat_row : row_cnt;
  assign we0   = (cmd.cell_wr && !cur_sel) || (cmd.adv_row && cur_sel);
  assign we1   = (cmd.cell_wr && cur_sel) || (cmd.adv_row && !cur_sel);

  life_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (q0)
  );

  life_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (q1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.cell_out <= (lat.mode == MODE_READ) && !lat_bad && cell_bit;
      result.status   <= lat_bad;
    end
  end

endmodule
